// ===== sv/box_blur_3x3_zero_pad_core_defines.svh =====
// Assertion macros shared by the 3x3 box blur RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef BOX_BLUR_3X3_ZERO_PAD_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_ZERO_PAD_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define BB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define BB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bblur3_pkg.sv =====
// Shared constants, codes and request types of the 3x3 box blur core.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package bblur3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Column and row positions, and dimension values that may equal the maximum
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

    // Line memory: one word per column, one byte lane per row slot
    localparam int ROW_SLOTS = 4;
    localparam int LANE_W    = $clog2(ROW_SLOTS);
    localparam int WORD_W    = ROW_SLOTS * PIX_W;

    // Nine 8-bit taps plus rounding bias; divide by nine as (x * 3641) >> 15
    localparam int SUM_W      = 12;
    localparam int ROUND_BIAS = 4;
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_MUL_W = 12;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = SUM_W + DIV9_MUL_W;

    localparam int RESET_WIDTH  = 64;
    localparam int RESET_HEIGHT = 64;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Pixel write into the line memory
    typedef struct packed {
        logic              vld;
        logic [COL_W-1:0]  col;
        logic [LANE_W-1:0] lane;
        logic [PIX_W-1:0]  data;
    } wr_req_t;

    // Neighborhood fetch for one result: center column and the one to its right
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [COL_W-1:0]  col_a;
        logic [COL_W-1:0]  col_b;
        logic [LANE_W-1:0] lane_up;
        logic [LANE_W-1:0] lane_mid;
        logic [LANE_W-1:0] lane_dn;
        logic              up_ok;
        logic              dn_ok;
        logic              lf_ok;
        logic              rt_ok;
    } rd_req_t;

endpackage

`default_nettype wire

// ===== sv/box_blur_3x3_zero_pad_core.sv =====
// Top level of the 3x3 zero-padded box blur; instantiates bblur3_ctrl,
// bblur3_linemem, bblur3_window and bblur3_outq, and uses bblur3_pkg.
//
// Pixels enter in raster order on the s_ side, one per clock while s_tready is
// high, and each output pixel is (sum of in-frame 3x3 neighbors + 4) / 9 with
// off-frame taps as zero. An item (pixel or drain) releases at most one
// result, as soon as that result's neighborhood has arrived, so results trail
// the input by about one row plus one pixel; drains (s_tuser = 1) flush the
// last row. A pixel sent after the last pixel of the frame, while that frame
// still has results pending, is dropped and releases nothing. The input rate
// is set by the column-wide line memory, which takes one pixel write and two
// column reads (center and right column) per clock. A result passes the
// registered line memory read, the sum register and the result queue before
// it reaches m_tdata, and s_tready drops while four results are outstanding.
// A register write restarts the frame. The line memory is not cleared after
// reset; entries are only read once written for the current positions.
`default_nettype none

module box_blur_3x3_zero_pad_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [bblur3_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [bblur3_pkg::CFG_W-1:0]     cfg_wr_data,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bblur3_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel_value
    input  wire logic                             s_tuser,   // [0] command
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bblur3_pkg::PIX_W-1:0]          m_tdata,   // [7:0] blurred_value
    output logic                                  m_tlast
);

    bblur3_pkg::wr_req_t           wr_req;
    bblur3_pkg::rd_req_t           rd_req;
    logic                          emit;
    logic                          s_xfer;
    logic [bblur3_pkg::WORD_W-1:0] mem_a_data;
    logic [bblur3_pkg::WORD_W-1:0] mem_b_data;
    logic                          res_vld;
    logic                          res_last;
    logic [bblur3_pkg::PIX_W-1:0]  res_data;

    assign s_xfer = s_tvalid && s_tready;

    bblur3_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .item_xfer    (s_xfer),
        .item_cmd     (s_tuser),
        .item_pixel   (s_tdata),
        .wr_req       (wr_req),
        .rd_req       (rd_req),
        .emit         (emit)
    );

    bblur3_linemem u_linemem (
        .aclk      (aclk),
        .wr_req    (wr_req),
        .rd_a_addr (rd_req.col_a),
        .rd_b_addr (rd_req.col_b),
        .rd_a_data (mem_a_data),
        .rd_b_data (mem_b_data)
    );

    bblur3_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_req     (rd_req),
        .wr_req     (wr_req),
        .mem_a_data (mem_a_data),
        .mem_b_data (mem_b_data),
        .res_vld    (res_vld),
        .res_last   (res_last),
        .res_data   (res_data)
    );

    bblur3_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .res_vld  (res_vld),
        .res_last (res_last),
        .res_data (res_data),
        .s_ready  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sv/bblur3_linemem.sv =====
// Line memory of the box blur: one word per column, a byte lane per row slot.
// One byte-lane write port, two registered read ports. Uses bblur3_pkg.
`default_nettype none

module bblur3_linemem (
    input  wire logic                         aclk,
    input  wire bblur3_pkg::wr_req_t          wr_req,
    input  wire logic [bblur3_pkg::COL_W-1:0] rd_a_addr,
    input  wire logic [bblur3_pkg::COL_W-1:0] rd_b_addr,
    output logic [bblur3_pkg::WORD_W-1:0]     rd_a_data,
    output logic [bblur3_pkg::WORD_W-1:0]     rd_b_data
);

    logic [bblur3_pkg::WORD_W-1:0] mem [bblur3_pkg::MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_req.vld) begin
            mem[wr_req.col][wr_req.lane*bblur3_pkg::PIX_W +: bblur3_pkg::PIX_W] <= wr_req.data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

// ===== sv/bblur3_ctrl.sv =====
// Position tracking of the box blur: input and result counters, frame size
// registers, line memory writes and neighborhood fetch requests. Uses bblur3_pkg.
`default_nettype none

module bblur3_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bblur3_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [bblur3_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                             item_xfer,
    input  wire logic                             item_cmd,
    input  wire logic [bblur3_pkg::PIX_W-1:0]     item_pixel,
    output bblur3_pkg::wr_req_t                   wr_req,
    output bblur3_pkg::rd_req_t                   rd_req,
    output logic                                  emit
);

    `include "box_blur_3x3_zero_pad_core_defines.svh"

    logic [bblur3_pkg::WDIM_W-1:0] eff_w_reg, eff_w_next;
    logic [bblur3_pkg::HDIM_W-1:0] eff_h_reg, eff_h_next;
    logic [bblur3_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [bblur3_pkg::HDIM_W-1:0] in_row_reg, in_row_next;
    logic [bblur3_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [bblur3_pkg::ROW_W-1:0]  out_row_reg, out_row_next;

    logic [bblur3_pkg::WDIM_W-1:0] col_inc;
    logic                          col_wrap;
    logic                          pix;
    logic [bblur3_pkg::COL_W-1:0]  rcv_col;
    logic [bblur3_pkg::HDIM_W-1:0] rcv_row;
    logic [bblur3_pkg::WDIM_W-1:0] ocol_inc;
    logic [bblur3_pkg::HDIM_W-1:0] orow_inc;
    logic                          dn_ok;
    logic                          rt_ok;
    logic [bblur3_pkg::WDIM_W-1:0] need_col;
    logic [bblur3_pkg::HDIM_W-1:0] need_row;
    logic                          ready;
    logic                          frame_end;
    logic [bblur3_pkg::LANE_W-1:0] lane_mid;

    // Zero acts as one, anything above the maximum as the maximum
    function automatic int clamp_dim(input logic [bblur3_pkg::CFG_W-1:0] v, input int max_v);
        int r;
        r = int'(v);
        if (r == 0) begin
            r = 1;
        end else if (r > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

    always_comb begin
        col_inc  = bblur3_pkg::WDIM_W'(in_col_reg) + bblur3_pkg::WDIM_W'(1);
        col_wrap = (col_inc == eff_w_reg);
        pix      = item_xfer && (item_cmd == bblur3_pkg::CMD_PIXEL) && (in_row_reg < eff_h_reg);

        // Input position after this item's pixel is stored
        rcv_col = in_col_reg;
        rcv_row = in_row_reg;
        if (pix) begin
            if (col_wrap) begin
                rcv_col = '0;
                rcv_row = in_row_reg + bblur3_pkg::HDIM_W'(1);
            end else begin
                rcv_col = col_inc[bblur3_pkg::COL_W-1:0];
            end
        end

        ocol_inc = bblur3_pkg::WDIM_W'(out_col_reg) + bblur3_pkg::WDIM_W'(1);
        orow_inc = bblur3_pkg::HDIM_W'(out_row_reg) + bblur3_pkg::HDIM_W'(1);
        rt_ok    = (ocol_inc < eff_w_reg);
        dn_ok    = (orow_inc < eff_h_reg);

        // Last pixel the next result depends on, clipped to the frame
        need_col = rt_ok ? ocol_inc : bblur3_pkg::WDIM_W'(out_col_reg);
        need_row = dn_ok ? orow_inc : bblur3_pkg::HDIM_W'(out_row_reg);
        ready    = (rcv_row > need_row) ||
                   ((rcv_row == need_row) && (bblur3_pkg::WDIM_W'(rcv_col) > need_col));
        // A pixel past the end of the frame is dropped and releases nothing
        emit      = item_xfer && ready &&
                    !((item_cmd == bblur3_pkg::CMD_PIXEL) && (in_row_reg >= eff_h_reg));
        frame_end = !rt_ok && !dn_ok;
        lane_mid  = out_row_reg[bblur3_pkg::LANE_W-1:0];
    end

    always_comb begin
        wr_req.vld  = pix;
        wr_req.col  = in_col_reg;
        wr_req.lane = in_row_reg[bblur3_pkg::LANE_W-1:0];
        wr_req.data = item_pixel;

        rd_req.vld      = emit;
        rd_req.last     = frame_end;
        rd_req.col_a    = out_col_reg;
        rd_req.col_b    = ocol_inc[bblur3_pkg::COL_W-1:0];
        rd_req.lane_up  = lane_mid - bblur3_pkg::LANE_W'(1);
        rd_req.lane_mid = lane_mid;
        rd_req.lane_dn  = lane_mid + bblur3_pkg::LANE_W'(1);
        rd_req.up_ok    = (out_row_reg != '0);
        rd_req.dn_ok    = dn_ok;
        rd_req.lf_ok    = (out_col_reg != '0);
        rd_req.rt_ok    = rt_ok;
    end

    always_comb begin
        eff_w_next   = eff_w_reg;
        eff_h_next   = eff_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                bblur3_pkg::REG_IMAGE_WIDTH: begin
                    eff_w_next   = bblur3_pkg::WDIM_W'(clamp_dim(cfg_wr_data,
                                                                 bblur3_pkg::MAX_WIDTH));
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                bblur3_pkg::REG_IMAGE_HEIGHT: begin
                    eff_h_next   = bblur3_pkg::HDIM_W'(clamp_dim(cfg_wr_data,
                                                                 bblur3_pkg::MAX_HEIGHT));
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                default: begin
                end
            endcase
        end else if (emit && frame_end) begin
            // Frame done: restart every counter
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else begin
            in_col_next = rcv_col;
            in_row_next = rcv_row;
            if (emit) begin
                if (rt_ok) begin
                    out_col_next = ocol_inc[bblur3_pkg::COL_W-1:0];
                end else begin
                    out_col_next = '0;
                    out_row_next = orow_inc[bblur3_pkg::ROW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg   <= bblur3_pkg::WDIM_W'(bblur3_pkg::RESET_WIDTH);
            eff_h_reg   <= bblur3_pkg::HDIM_W'(bblur3_pkg::RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            eff_w_reg   <= eff_w_next;
            eff_h_reg   <= eff_h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    `BB_ASSERT_ALWAYS(a_ctl_in_pos_range,
        bblur3_pkg::WDIM_W'(in_col_reg) < eff_w_reg && in_row_reg <= eff_h_reg,
        "input position outside frame")
    `BB_ASSERT_ALWAYS(a_ctl_out_pos_range,
        bblur3_pkg::WDIM_W'(out_col_reg) < eff_w_reg && bblur3_pkg::HDIM_W'(out_row_reg) < eff_h_reg,
        "result position outside frame")
    `BB_ASSERT_NEXT(a_ctl_frame_restart, emit && frame_end,
        in_row_reg == '0 && in_col_reg == '0 && out_row_reg == '0 && out_col_reg == '0,
        "counters not cleared after last result of frame")

endmodule

`default_nettype wire

// ===== sv/bblur3_window.sv =====
// Neighborhood assembly and averaging of the box blur: forwards the same-cycle
// write, masks out-of-frame taps, sums nine taps and divides by nine. Uses bblur3_pkg.
`default_nettype none

module bblur3_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bblur3_pkg::rd_req_t           rd_req,
    input  wire bblur3_pkg::wr_req_t           wr_req,
    input  wire logic [bblur3_pkg::WORD_W-1:0] mem_a_data,
    input  wire logic [bblur3_pkg::WORD_W-1:0] mem_b_data,
    output logic                               res_vld,
    output logic                               res_last,
    output logic [bblur3_pkg::PIX_W-1:0]       res_data
);

    bblur3_pkg::rd_req_t          req_reg;
    bblur3_pkg::wr_req_t          fwd_reg;
    logic [bblur3_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                         s1_vld_reg;
    logic                         s1_last_reg;
    logic [bblur3_pkg::PIX_W-1:0] left_reg [3];

    logic [bblur3_pkg::WORD_W-1:0] word_a, word_b;
    logic [bblur3_pkg::PIX_W-1:0]  tap_a [3];
    logic [bblur3_pkg::PIX_W-1:0]  tap_b [3];
    logic [bblur3_pkg::PIX_W-1:0]  tap_l [3];
    logic [bblur3_pkg::LANE_W-1:0] lanes [3];
    logic                          row_ok [3];
    logic [bblur3_pkg::PROD_W-1:0] prod;

    // The memory returns data from before this cycle's write; patch that lane in
    function automatic logic [bblur3_pkg::WORD_W-1:0] fwd_merge(
        input logic [bblur3_pkg::WORD_W-1:0] word,
        input bblur3_pkg::wr_req_t           wr,
        input logic [bblur3_pkg::COL_W-1:0]  col
    );
        logic [bblur3_pkg::WORD_W-1:0] r;
        r = word;
        if (wr.vld && (wr.col == col)) begin
            r[wr.lane*bblur3_pkg::PIX_W +: bblur3_pkg::PIX_W] = wr.data;
        end
        return r;
    endfunction

    always_comb begin
        word_a = fwd_merge(mem_a_data, fwd_reg, req_reg.col_a);
        word_b = fwd_merge(mem_b_data, fwd_reg, req_reg.col_b);

        lanes[0]  = req_reg.lane_up;
        lanes[1]  = req_reg.lane_mid;
        lanes[2]  = req_reg.lane_dn;
        row_ok[0] = req_reg.up_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = req_reg.dn_ok;

        sum_next = bblur3_pkg::SUM_W'(bblur3_pkg::ROUND_BIAS);
        for (int i = 0; i < 3; i++) begin
            tap_a[i] = row_ok[i] ? word_a[lanes[i]*bblur3_pkg::PIX_W +: bblur3_pkg::PIX_W] : '0;
            tap_b[i] = (row_ok[i] && req_reg.rt_ok) ?
                       word_b[lanes[i]*bblur3_pkg::PIX_W +: bblur3_pkg::PIX_W] : '0;
            tap_l[i] = req_reg.lf_ok ? left_reg[i] : '0;
            sum_next = sum_next + bblur3_pkg::SUM_W'(tap_a[i]) + bblur3_pkg::SUM_W'(tap_b[i])
                       + bblur3_pkg::SUM_W'(tap_l[i]);
        end

        prod     = bblur3_pkg::PROD_W'(sum_reg) * bblur3_pkg::PROD_W'(bblur3_pkg::DIV9_MUL);
        res_data = prod[bblur3_pkg::DIV9_SHIFT +: bblur3_pkg::PIX_W];
        res_vld  = s1_vld_reg;
        res_last = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg    <= '0;
            fwd_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end else begin
            req_reg    <= rd_req;
            fwd_reg    <= wr_req;
            s1_vld_reg <= req_reg.vld;
        end
        sum_reg     <= sum_next;
        s1_last_reg <= req_reg.last;
        // Center column becomes the left column of the next result
        if (req_reg.vld) begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i] <= tap_a[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bblur3_outq.sv =====
// Result queue of the box blur: holds finished results for the master port and
// counts outstanding results to throttle the input side. Uses bblur3_pkg.
`default_nettype none

module bblur3_outq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         emit,
    input  wire logic                         res_vld,
    input  wire logic                         res_last,
    input  wire logic [bblur3_pkg::PIX_W-1:0] res_data,
    output logic                              s_ready,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [bblur3_pkg::PIX_W-1:0]      m_tdata,
    output logic                              m_tlast
);

    `include "box_blur_3x3_zero_pad_core_defines.svh"

    logic [bblur3_pkg::PIX_W:0]      q_mem [bblur3_pkg::OQ_DEPTH];
    logic [bblur3_pkg::OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bblur3_pkg::OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bblur3_pkg::OQ_CNT_W-1:0] fill_reg, fill_next;
    logic [bblur3_pkg::OQ_CNT_W-1:0] pending_reg, pending_next;
    logic                            m_xfer;

    always_comb begin
        m_tvalid = (fill_reg != '0);
        m_tlast  = q_mem[rd_ptr_reg][bblur3_pkg::PIX_W];
        m_tdata  = q_mem[rd_ptr_reg][bblur3_pkg::PIX_W-1:0];
        m_xfer   = m_tvalid && m_tready;
        // Every outstanding result owns a queue slot, so the queue never overflows
        s_ready  = aresetn && (pending_reg < bblur3_pkg::OQ_CNT_W'(bblur3_pkg::OQ_DEPTH));

        wr_ptr_next  = res_vld ? wr_ptr_reg + bblur3_pkg::OQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = m_xfer ? rd_ptr_reg + bblur3_pkg::OQ_PTR_W'(1) : rd_ptr_reg;
        fill_next    = fill_reg + bblur3_pkg::OQ_CNT_W'(res_vld)
                       - bblur3_pkg::OQ_CNT_W'(m_xfer);
        pending_next = pending_reg + bblur3_pkg::OQ_CNT_W'(emit)
                       - bblur3_pkg::OQ_CNT_W'(m_xfer);
    end

    always_ff @(posedge aclk) begin
        if (res_vld) begin
            q_mem[wr_ptr_reg] <= {res_last, res_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            pending_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
        end
    end

    `BB_ASSERT_IMPLY(a_oq_no_overflow, res_vld,
        fill_reg < bblur3_pkg::OQ_CNT_W'(bblur3_pkg::OQ_DEPTH),
        "result written into a full queue")
    `BB_ASSERT_ALWAYS(a_oq_fill_le_pending, fill_reg <= pending_reg,
        "more queued results than outstanding results")
    `BB_ASSERT_ALWAYS(a_oq_pending_bound,
        pending_reg <= bblur3_pkg::OQ_CNT_W'(bblur3_pkg::OQ_DEPTH),
        "more outstanding results than queue slots")

endmodule

`default_nettype wire

// ===== test/tb_box_blur_3x3_zero_pad_core.sv =====
// Self-checking testbench for box_blur_3x3_zero_pad_core: raster frames of 8-bit pixels
// and drain items stream in, and every blurred pixel is checked against a predictor.
// Depends on bblur3_pkg and the core RTL only.
module tb_box_blur_3x3_zero_pad_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_AFTER     = 100;
    localparam int DRAIN_LATENCY  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_pace_t;

    // Predicts blurred pixels from accepted items and checks results in order
    class blur_scoreboard;
        typedef struct {
            logic [bblur3_pkg::PIX_W-1:0] value;
            logic                         last;
        } blurred_t;

        logic [bblur3_pkg::CFG_W-1:0] width_reg  =
            bblur3_pkg::CFG_W'(bblur3_pkg::RESET_WIDTH);
        logic [bblur3_pkg::CFG_W-1:0] height_reg =
            bblur3_pkg::CFG_W'(bblur3_pkg::RESET_HEIGHT);
        logic [bblur3_pkg::PIX_W-1:0] rows [bblur3_pkg::ROW_SLOTS][bblur3_pkg::MAX_WIDTH];
        int unsigned      in_col;
        int unsigned      in_row;
        int unsigned      out_idx;
        blurred_t         blurred_q[$];
        int unsigned      errors;

        function new();
            foreach (rows[r, c]) rows[r][c] = '0;
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
            errors  = 0;
        endfunction

        static function int unsigned clamp_dim(logic [bblur3_pkg::CFG_W-1:0] v,
                                               int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void write_reg(logic [bblur3_pkg::CFG_IDX_W-1:0] idx,
                                logic [bblur3_pkg::CFG_W-1:0] val);
            if (idx == bblur3_pkg::REG_IMAGE_WIDTH) width_reg = val;
            else height_reg = val;
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
        endfunction

        function void note_item(logic cmd, logic [bblur3_pkg::PIX_W-1:0] pix);
            int unsigned w, h, total, got, orow, ocol, nrow, ncol, sum;
            int r, c;
            blurred_t res;
            w = clamp_dim(width_reg, bblur3_pkg::MAX_WIDTH);
            h = clamp_dim(height_reg, bblur3_pkg::MAX_HEIGHT);
            if (cmd == bblur3_pkg::CMD_PIXEL) begin
                // a pixel past the complete frame is dropped without releasing anything
                if (in_row >= h) return;
                if (in_col >= w) in_col = w - 1;
                rows[in_row % bblur3_pkg::ROW_SLOTS][in_col] = pix;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            total = w * h;
            got   = in_row * w + in_col;
            if (out_idx >= total) return;
            orow = out_idx / w;
            ocol = out_idx % w;
            nrow = (orow + 1 < h) ? orow + 1 : h - 1;
            ncol = (ocol + 1 < w) ? ocol + 1 : w - 1;
            if (got <= nrow * w + ncol) return;
            sum = 0;
            for (r = int'(orow) - 1; r <= int'(orow) + 1; r++) begin
                for (c = int'(ocol) - 1; c <= int'(ocol) + 1; c++) begin
                    if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w))
                        sum += rows[r % bblur3_pkg::ROW_SLOTS][c];
                end
            end
            res.value = bblur3_pkg::PIX_W'((sum + 4) / 9);
            res.last  = (out_idx == total - 1);
            if (res.last) begin
                in_col  = 0;
                in_row  = 0;
                out_idx = 0;
            end else begin
                out_idx++;
            end
            blurred_q.push_back(res);
        endfunction

        function void check_blurred(logic [bblur3_pkg::PIX_W-1:0] value, logic last);
            blurred_t exp_res;
            if (blurred_q.size() == 0) begin
                $error("unexpected result: blurred_value %0d, frame_last %0b", value, last);
                errors++;
                return;
            end
            exp_res = blurred_q.pop_front();
            if (value !== exp_res.value) begin
                $error("blurred_value mismatch: expected %0d, actual %0d", exp_res.value, value);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("frame_last mismatch: expected %0b, actual %0b", exp_res.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction
    endclass

    logic                                 aclk         = 1'b0;
    logic                                 aresetn      = 1'b0;
    logic                                 cfg_wr_en    = 1'b0;
    logic [bblur3_pkg::CFG_IDX_W-1:0]     cfg_wr_index = bblur3_pkg::REG_IMAGE_WIDTH;
    logic [bblur3_pkg::CFG_W-1:0]         cfg_wr_data  = '0;
    logic                                 s_tvalid     = 1'b0;
    logic                                 s_tready;
    logic [bblur3_pkg::PIX_W-1:0]         s_tdata      = '0;   // [7:0] pixel_value
    logic                                 s_tuser      = bblur3_pkg::CMD_PIXEL;   // [0] command
    logic                                 m_tvalid;
    logic                                 m_tready     = 1'b0;
    logic [bblur3_pkg::PIX_W-1:0]         m_tdata;             // [7:0] blurred_value
    logic                                 m_tlast;

    blur_scoreboard sb = new();
    int  burst_left  = 0;
    bit  tx_no_gaps  = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  item_count  = 0;
    int  quiet_cycles = 0;

    box_blur_3x3_zero_pad_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [bblur3_pkg::PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = (tx_no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        // let the monitor note the last transfer before looking at the queue
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_LATENCY) @(posedge aclk);
    endtask

    task automatic set_dims(input logic [bblur3_pkg::CFG_W-1:0] w,
                            input logic [bblur3_pkg::CFG_W-1:0] h);
        settle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= bblur3_pkg::REG_IMAGE_WIDTH;
        cfg_wr_data  <= w;
        @(posedge aclk);
        cfg_wr_index <= bblur3_pkg::REG_IMAGE_HEIGHT;
        cfg_wr_data  <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send cut pixels of a w x h frame; a complete frame is flushed with drains
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned cut, input bit noisy);
        int unsigned n;
        int style;
        logic [bblur3_pkg::PIX_W-1:0] pix;
        style = $urandom_range(0, 2);
        if (noisy && $urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3))
                send_item(bblur3_pkg::CMD_DRAIN, bblur3_pkg::PIX_W'($urandom));
        for (n = 0; n < cut; n++) begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_item(bblur3_pkg::CMD_DRAIN, bblur3_pkg::PIX_W'($urandom));
            case (style)
                0: pix = bblur3_pkg::PIX_W'($urandom);
                1: pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                default: pix = ($urandom_range(0, 1) == 1) ?
                               bblur3_pkg::PIX_W'($urandom_range(240, 255)) :
                               bblur3_pkg::PIX_W'($urandom_range(0, 15));
            endcase
            send_item(bblur3_pkg::CMD_PIXEL, pix);
            item_count++;
        end
        if (cut == w * h) begin
            // pixels past the end of the frame must be ignored
            if (noisy)
                repeat ($urandom_range(1, 3))
                    send_item(bblur3_pkg::CMD_PIXEL, bblur3_pkg::PIX_W'($urandom));
            // a single row leaves one result pending, taller frames about a row
            repeat ((h > 1) ? w + 3 : 3)
                send_item(bblur3_pkg::CMD_DRAIN, bblur3_pkg::PIX_W'($urandom));
        end
    endtask

    // Receiver pacing; a hold request stalls it for a long stretch
    initial begin : rx_pacing
        int hold_left, mode_left;
        int unsigned tick;
        rx_pace_t mode;
        hold_left = 0;
        mode_left = 0;
        tick      = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = rx_pace_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
                    RX_QUARTER: m_tready <= (tick % 4 == 0);
                    default:    m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Observe transfers and register writes; end the run if traffic stops
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.write_reg(cfg_wr_index, cfg_wr_data);
            if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_blurred(m_tdata, m_tlast);
            if (cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned w, h, frames, k;
        logic [bblur3_pkg::CFG_W-1:0] wr, hr;
        bit hold_done;
        hold_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // drain on an empty block, a saturated 3x3 frame, pixels past its end
        set_dims(11'd3, 11'd3);
        send_item(bblur3_pkg::CMD_DRAIN, 8'hFF);
        repeat (9) send_item(bblur3_pkg::CMD_PIXEL, 8'hFF);
        repeat (2) send_item(bblur3_pkg::CMD_PIXEL, 8'h00);
        repeat (6) send_item(bblur3_pkg::CMD_DRAIN, 8'h00);
        // zero sizes act as one: each pixel is a whole frame
        set_dims(11'd0, 11'd0);
        send_item(bblur3_pkg::CMD_PIXEL, 8'hA5);
        send_item(bblur3_pkg::CMD_PIXEL, 8'h5A);

        // widest row: an oversize width clamps to the maximum, zero height acts as one
        set_dims(11'd2047, 11'd0);
        send_frame(bblur3_pkg::MAX_WIDTH, 1, bblur3_pkg::MAX_WIDTH, 1'b0);

        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 48) : $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            if (!hold_done && item_count >= HOLD_AFTER) begin
                // big enough frame that the stalled output backs up into the input
                w = 8;
                h = 6;
            end
            wr = bblur3_pkg::CFG_W'(w);
            hr = bblur3_pkg::CFG_W'(h);
            if (w == 1 && $urandom_range(0, 1) == 1) wr = '0;
            if (h == 1 && $urandom_range(0, 1) == 1) hr = '0;
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            set_dims(wr, hr);
            if (!hold_done && item_count >= HOLD_AFTER) begin
                rx_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            frames = $urandom_range(1, 3);
            for (k = 0; k < frames; k++) begin
                if (k == frames - 1 && $urandom_range(0, 5) == 0)
                    send_frame(w, h, $urandom_range(0, w * h - 1), 1'b1);
                else
                    send_frame(w, h, w * h, $urandom_range(0, 2) == 0);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/bblur3_pkg.sv
sv/bblur3_linemem.sv
sv/bblur3_ctrl.sv
sv/bblur3_window.sv
sv/bblur3_outq.sv
sv/box_blur_3x3_zero_pad_core.sv
test/tb_box_blur_3x3_zero_pad_core.sv
